>>> hdl/cmfuv_pkg.sv
// ----------------------------------------------------------------------------
// cmfuv_pkg: cube map face and uv shared types
// Widths, face codes and the transfer structs used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfuv_pkg;

  localparam int unsigned COMPONENT_BITS = 16;
  localparam int unsigned UV_BITS        = 16;
  // sum m+M and divisor 2M both fit in COMPONENT_BITS+1 bits
  localparam int unsigned SUM_BITS       = COMPONENT_BITS + 1;
  // numerator UV_MAX*s + M
  localparam int unsigned NUM_BITS       = COMPONENT_BITS + UV_BITS + 1;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [UV_BITS-1:0] UV_HALF = {1'b1, {(UV_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] dir_x;
    logic signed [COMPONENT_BITS-1:0] dir_y;
    logic signed [COMPONENT_BITS-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    face_e              face;
    logic [UV_BITS-1:0] tex_u;
    logic [UV_BITS-1:0] tex_v;
    logic               zero_direction;
  } res_t;

  // classified item: face, major magnitude and both offset minors (m + M)
  typedef struct packed {
    face_e                     face;
    logic                      zero_direction;
    logic [COMPONENT_BITS-1:0] big;
    logic [SUM_BITS-1:0]       sum_u;
    logic [SUM_BITS-1:0]       sum_v;
  } cls_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic vld;
    cls_t item;
  } qhead_t;

  // one divider lane: partial remainder, numerator bits / quotient bits
  typedef struct packed {
    logic [SUM_BITS-1:0] rem;
    logic [UV_BITS-1:0]  lq;
  } lane_t;

endpackage

`default_nettype wire

>>> hdl/cmfuv_front.sv
// ----------------------------------------------------------------------------
// cmfuv_front: direction classifier
// Picks the major axis and face, forms the minor components per face.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfuv_front (
  input  logic            in_valid_i,
  input  cmfuv_pkg::dir_t in_data_i,
  output logic            push_o,
  output cmfuv_pkg::cls_t item_o
);

  localparam int unsigned CB = cmfuv_pkg::COMPONENT_BITS;
  localparam int unsigned SB = cmfuv_pkg::SUM_BITS;

  logic signed [CB+1:0] xe, ye, ze;
  logic signed [CB+1:0] nx, ny, nz;
  logic [CB-1:0]        ax, ay, az;
  logic [CB-1:0]        big;
  logic signed [CB+1:0] mu, mv;
  logic signed [CB+1:0] sum_u, sum_v;
  logic                 all_zero;
  cmfuv_pkg::face_e     face;

  assign xe = {{2{in_data_i.dir_x[CB-1]}}, in_data_i.dir_x};
  assign ye = {{2{in_data_i.dir_y[CB-1]}}, in_data_i.dir_y};
  assign ze = {{2{in_data_i.dir_z[CB-1]}}, in_data_i.dir_z};
  assign nx = -xe;
  assign ny = -ye;
  assign nz = -ze;

  // magnitude of the most negative value fits in CB unsigned bits
  assign ax = xe[CB+1] ? nx[CB-1:0] : xe[CB-1:0];
  assign ay = ye[CB+1] ? ny[CB-1:0] : ye[CB-1:0];
  assign az = ze[CB+1] ? nz[CB-1:0] : ze[CB-1:0];

  assign all_zero = (ax == '0) && (ay == '0) && (az == '0);

  always_comb begin
    if (all_zero) begin
      // m = 0, M = 1 lands exactly on one half rounded up
      face = cmfuv_pkg::FACE_POS_Z;
      big  = CB'(1);
      mu   = '0;
      mv   = '0;
    end else if (ax >= ay && ax >= az) begin
      big = ax;
      mv  = ny;
      if (!xe[CB+1]) begin
        face = cmfuv_pkg::FACE_POS_X;
        mu   = nz;
      end else begin
        face = cmfuv_pkg::FACE_NEG_X;
        mu   = ze;
      end
    end else if (ay >= az) begin
      big = ay;
      mu  = xe;
      if (!ye[CB+1]) begin
        face = cmfuv_pkg::FACE_POS_Y;
        mv   = ze;
      end else begin
        face = cmfuv_pkg::FACE_NEG_Y;
        mv   = nz;
      end
    end else begin
      big = az;
      mv  = ny;
      if (!ze[CB+1]) begin
        face = cmfuv_pkg::FACE_POS_Z;
        mu   = xe;
      end else begin
        face = cmfuv_pkg::FACE_NEG_Z;
        mu   = nx;
      end
    end
  end

  // |m| <= M, so m + M lies in [0, 2M]
  assign sum_u = mu + $signed({2'b00, big});
  assign sum_v = mv + $signed({2'b00, big});

  assign push_o                = in_valid_i;
  assign item_o.face           = face;
  assign item_o.zero_direction = all_zero;
  assign item_o.big            = big;
  assign item_o.sum_u          = sum_u[SB-1:0];
  assign item_o.sum_v          = sum_v[SB-1:0];

endmodule

`default_nettype wire

>>> hdl/cmfuv_queue.sv
// ----------------------------------------------------------------------------
// cmfuv_queue: front to back queue
// Small register queue so front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfuv_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cmfuv_pkg::cls_t   item_i,
  input  logic              pop_i,
  output logic              full_o,
  output cmfuv_pkg::qhead_t head_o
);

  localparam int unsigned DEPTH = cmfuv_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmfuv_pkg::cls_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign head_o.vld  = (cnt_q != '0);
  assign head_o.item = mem_q[rd_q];

endmodule

`default_nettype wire

>>> hdl/cmfuv_back.sv
// ----------------------------------------------------------------------------
// cmfuv_back: uv divider pipeline
// Forms UV_MAX*s + M, then one restoring quotient bit per stage, two lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfuv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmfuv_pkg::qhead_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cmfuv_pkg::res_t   out_data_o
);

  localparam int unsigned CB = cmfuv_pkg::COMPONENT_BITS;
  localparam int unsigned UB = cmfuv_pkg::UV_BITS;
  localparam int unsigned SB = cmfuv_pkg::SUM_BITS;
  localparam int unsigned NB = cmfuv_pkg::NUM_BITS;

  typedef struct packed {
    cmfuv_pkg::face_e face;
    logic             zero_direction;
    logic [SB-1:0]    div;
    cmfuv_pkg::lane_t u;
    cmfuv_pkg::lane_t v;
  } stg_t;

  // numerator = (s << UB) - s + M, split into remainder seed and low bits
  function automatic cmfuv_pkg::lane_t init_lane(input logic [SB-1:0] sum,
                                                 input logic [CB-1:0] big);
    logic [NB:0]      num;
    cmfuv_pkg::lane_t l;
    num   = {1'b0, sum, {UB{1'b0}}} - {{(UB+1){1'b0}}, sum}
          + {{(UB+2){1'b0}}, big};
    l.rem = num[NB-1:UB];
    l.lq  = num[UB-1:0];
    return l;
  endfunction

  function automatic cmfuv_pkg::lane_t step_lane(input cmfuv_pkg::lane_t l,
                                                 input logic [SB-1:0] div);
    logic [SB:0]      t;
    logic             qb;
    cmfuv_pkg::lane_t r;
    t  = {l.rem, l.lq[UB-1]};
    qb = 1'b0;
    if (t >= {1'b0, div}) begin
      t  = t - {1'b0, div};
      qb = 1'b1;
    end
    r.rem = t[SB-1:0];
    r.lq  = {l.lq[UB-2:0], qb};
    return r;
  endfunction

  stg_t        stg_q [UB+1];
  stg_t        stg_d [UB+1];
  logic [UB:0] vld_q;
  logic        adv;

  // whole pipe moves unless the last stage holds a stalled result
  assign adv   = !(vld_q[UB] && out_stall_i);
  assign pop_o = adv && head_i.vld;

  always_comb begin
    stg_d[0].face           = head_i.item.face;
    stg_d[0].zero_direction = head_i.item.zero_direction;
    stg_d[0].div            = {head_i.item.big, 1'b0};
    stg_d[0].u              = init_lane(head_i.item.sum_u, head_i.item.big);
    stg_d[0].v              = init_lane(head_i.item.sum_v, head_i.item.big);
    for (int k = 1; k <= UB; k++) begin
      stg_d[k].face           = stg_q[k-1].face;
      stg_d[k].zero_direction = stg_q[k-1].zero_direction;
      stg_d[k].div            = stg_q[k-1].div;
      stg_d[k].u              = step_lane(stg_q[k-1].u, stg_q[k-1].div);
      stg_d[k].v              = step_lane(stg_q[k-1].v, stg_q[k-1].div);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[UB-1:0], head_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= UB; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // quotient never exceeds UV_MAX since |m| <= M
  assign out_valid_o               = vld_q[UB];
  assign out_data_o.face           = stg_q[UB].face;
  assign out_data_o.tex_u          = stg_q[UB].u.lq;
  assign out_data_o.tex_v          = stg_q[UB].v.lq;
  assign out_data_o.zero_direction = stg_q[UB].zero_direction;

endmodule

`default_nettype wire

>>> hdl/cube_map_face_and_uv.sv
// ----------------------------------------------------------------------------
// cube_map_face_and_uv: cube map face selection with u/v coordinates
// Direction in, face index plus u/v fractions of UV_MAX out.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ------------------------------------
//  in       in   in_valid_i/in_stall_o  in_data_i  (dir_x, dir_y, dir_z)
//  out      out  out_valid_o/out_stall_i out_data_o (face, tex_u, tex_v, zero)
//
//  One transfer per cycle sustained in both directions while out_stall_i is low.
//  A direction passes the queue write, the numerator stage, then one
//  divider stage per quotient bit; the last stage is the output register.
//  Reset clears the queue count/pointers and the pipeline valid bits only.
//  An output stall freezes the divider pipe; the 2-entry queue then fills
//  and in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_map_face_and_uv (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cmfuv_pkg::dir_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cmfuv_pkg::res_t out_data_o
);

  logic              push;
  logic              pop;
  logic              full;
  cmfuv_pkg::cls_t   cls_item;
  cmfuv_pkg::qhead_t qhead;

  // front: classify the direction combinationally into the queue
  cmfuv_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .item_o     (cls_item)
  );

  // queue between classifier and divider; stall comes from a register
  cmfuv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (cls_item),
    .pop_i  (pop),
    .full_o (full),
    .head_o (qhead)
  );

  assign in_stall_o = full;

  // back: pipelined u/v division
  cmfuv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (qhead),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> hdl/cmfuv_checker.sv
// ----------------------------------------------------------------------------
// cmfuv_checker: port level checks
// Watches the top-level ports; bound into cube_map_face_and_uv.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfuv_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input cmfuv_pkg::dir_t in_data_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input cmfuv_pkg::res_t out_data_o
);

  // a stalled direction stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled direction changed");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // zero direction always reports +Z at one half
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_direction |->
      (out_data_o.face == cmfuv_pkg::FACE_POS_Z) &&
      (out_data_o.tex_u == cmfuv_pkg::UV_HALF) &&
      (out_data_o.tex_v == cmfuv_pkg::UV_HALF))
    else $error("zero direction result wrong");

  // queue fills only behind a held output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind cube_map_face_and_uv cmfuv_checker u_cmfuv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
